>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used by the slot table.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> sv/ept_pkg.sv
// ---------------------------------------------------------------------------
// ept_pkg
// Types and constants shared by the epoch-guarded slot table modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ept_pkg;

   localparam int SLOTS_DEFAULT = 1024;
   localparam int CSR_W         = 11;
   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;
   localparam int EPOCH_W       = 64;
   localparam int CIDX_W        = 10;
   localparam int REQ_DATA_W    = 272;
   localparam int RSP_DATA_W    = 208;
   localparam int DIVIDEND_W    = 64;

   localparam logic OP_PROBE  = 1'b0;
   localparam logic OP_COMMIT = 1'b1;

   localparam logic [1:0] ST_PROBE_OK = 2'd0;
   localparam logic [1:0] ST_NO_SLOTS = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_COMMIT   = 2'd3;

   localparam int FLAG_VALID = 0;
   localparam int FLAG_TOMB  = 1;

   typedef struct packed {
      logic [EPOCH_W-1:0] guard;
      logic [EPOCH_W-1:0] visible;
      logic [EPOCH_W-1:0] key;
      logic [1:0]         flags;
      logic [EPOCH_W-1:0] tie;
   } slot_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic               tomb;
      logic [CIDX_W-1:0]  cidx;
      logic [EPOCH_W-1:0] cguard;
      logic [EPOCH_W-1:0] ctie;
      logic [EPOCH_W-1:0] observed;
   } result_type;

   typedef struct packed {
      logic clr;
      logic load;
      logic div_start;
      logic walk_init;
      logic rd;
      logic step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic zero_probe;
      logic div_done;
      logic is_commit;
      logic walk_end;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

>>> sv/ept_mod_unit.sv
// ---------------------------------------------------------------------------
// ept_mod_unit
// Restoring remainder unit: one dividend bit per cycle, over every bit of the dividend.
// ---------------------------------------------------------------------------
`default_nettype none

module ept_mod_unit import ept_pkg::*; #(
   parameter int DW = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DW-1:0]         divisor,
   output logic                  done,
   output logic [DW-1:0]         remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DW-1:0]         dvs_ff, dvs_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [DW:0]           trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so one subtract suffices.
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DW'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = DW'(trial);
         end
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> sv/ept_datapath.sv
// ---------------------------------------------------------------------------
// ept_datapath
// Slot memory, request and walk registers, result and output registers.
// ---------------------------------------------------------------------------
`default_nettype none

module ept_datapath import ept_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_W-1:0]      csr_wr_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int XW = (CW > CSR_W) ? CW : CSR_W;
   // Reciprocal of the table size for reducing a commit's slot number.
   localparam int RECIP_SH = 20;
   localparam int RECIP    = (1 << RECIP_SH) / SLOTS;
   localparam int PW       = CIDX_W + RECIP_SH + 1;
   localparam int RW       = CIDX_W + 18;

   slot_type mem [SLOTS];

   logic [CSR_W-1:0]   csr_ff;
   logic               op_ff;
   logic [EPOCH_W-1:0] key_ff, cmp_ff, vis_ff, tie_ff;
   logic [1:0]         flags_ff;
   logic [CW-1:0]      n_ff, n_calc;
   logic [IW-1:0]      pos_ff, clr_ff, cand_ff;
   logic [CW-1:0]      cnt_ff;
   logic               have_ff;
   logic [EPOCH_W-1:0] cguard_ff, ctie_ff;
   slot_type           rd_ff;
   result_type         res_ff, out_ff;
   logic               rsp_valid_ff;
   logic [CIDX_W-1:0]  sidx_ff, quot_ff;

   logic [XW-1:0]         csr_x;
   logic [DIVIDEND_W-1:0] dividend;
   logic [CW-1:0]         divisor, rem;
   logic                  div_go;
   logic                  div_done;
   logic                  consistent, match, tomb_hit, empty, take, last, walk_end;
   logic                  have_next;
   logic [IW-1:0]         cand_next;
   logic [EPOCH_W-1:0]    cguard_next, ctie_next;
   logic                  mem_we;
   logic [IW-1:0]         mem_wa;
   slot_type              mem_wd;
   result_type            probe_res, commit_res, zero_res;
   logic [PW-1:0]         recip_prod;
   logic [CIDX_W-1:0]     quot_next;
   logic [RW-1:0]         back_prod, part_rem, slot_rem;

   // Slot count, clamped to the table size.
   always_comb begin
      csr_x  = XW'(csr_ff);
      n_calc = (csr_x > XW'(SLOTS)) ? CW'(SLOTS) : CW'(csr_x);
   end

   // Only a probe needs the remainder unit; it finds the home slot.
   assign dividend = req_tdata[63:0];
   assign divisor  = n_calc;
   assign div_go   = cmd.div_start && (req_tuser == OP_PROBE);

   ept_mod_unit #(.DW(CW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go),
      .dividend  (dividend),
      .divisor   (divisor),
      .done      (div_done),
      .remainder (rem)
   );

   // A commit's slot number is reduced modulo the table size. The estimated
   // quotient is at most one too small, so one compare and subtract finish it.
   always_comb begin
      recip_prod = PW'(req_tdata[73:64]) * PW'(RECIP);
      quot_next  = CIDX_W'(recip_prod >> RECIP_SH);
      back_prod  = RW'(quot_ff) * RW'(SLOTS);
      part_rem   = RW'(sidx_ff) - back_prod;
      slot_rem   = (part_rem >= RW'(SLOTS)) ? part_rem - RW'(SLOTS) : part_rem;
   end

   // Slot classification on the registered read data.
   always_comb begin
      consistent = (rd_ff.guard == rd_ff.visible);
      match      = consistent && rd_ff.flags[FLAG_VALID] && (rd_ff.key == key_ff);
      tomb_hit   = consistent && rd_ff.flags[FLAG_VALID] && rd_ff.flags[FLAG_TOMB];
      empty      = consistent && (rd_ff.guard == '0) && (rd_ff.key == '0)
                   && (rd_ff.flags == 2'b00);
      take       = (tomb_hit || empty) && !have_ff;
      last       = (cnt_ff == n_ff - CW'(1));
      walk_end   = match || empty || last;
      have_next  = have_ff || take;
      cand_next  = take ? pos_ff : cand_ff;
      cguard_next = take ? rd_ff.guard : cguard_ff;
      ctie_next   = take ? rd_ff.tie : ctie_ff;

      probe_res = '0;
      if (match) begin
         probe_res.status = ST_PROBE_OK;
         probe_res.found  = 1'b1;
         probe_res.tomb   = rd_ff.flags[FLAG_TOMB];
         probe_res.cidx   = CIDX_W'(pos_ff);
         probe_res.cguard = rd_ff.guard;
         probe_res.ctie   = rd_ff.tie;
      end else if (have_next) begin
         probe_res.status = ST_PROBE_OK;
         probe_res.cidx   = CIDX_W'(cand_next);
         probe_res.cguard = cguard_next;
         probe_res.ctie   = ctie_next;
      end else begin
         probe_res.status = ST_FULL;
      end

      commit_res          = '0;
      commit_res.status   = ST_COMMIT;
      commit_res.observed = rd_ff.guard;

      zero_res        = '0;
      zero_res.status = ST_NO_SLOTS;
   end

   // Memory write port: clearing sweep or commit.
   always_comb begin
      mem_we = cmd.clr || (cmd.step && (op_ff == OP_COMMIT));
      mem_wa = cmd.clr ? clr_ff : pos_ff;
      if (cmd.clr) begin
         mem_wd = '0;
      end else begin
         mem_wd.guard   = (rd_ff.guard == cmp_ff) ? vis_ff : rd_ff.guard;
         mem_wd.visible = vis_ff;
         mem_wd.key     = key_ff;
         mem_wd.flags   = flags_ff;
         mem_wd.tie     = tie_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.rd) begin
         rd_ff <= mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CSR_RESET;
         clr_ff       <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         if (cmd.clr) begin
            clr_ff <= clr_ff + IW'(1);
         end
         if (cmd.load) begin
            have_ff <= 1'b0;
         end else if (cmd.step) begin
            have_ff <= have_next;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_tuser;
         key_ff   <= req_tdata[63:0];
         sidx_ff  <= req_tdata[73:64];
         quot_ff  <= quot_next;
         cmp_ff   <= req_tdata[137:74];
         vis_ff   <= req_tdata[201:138];
         flags_ff <= req_tdata[203:202];
         tie_ff   <= req_tdata[267:204];
         n_ff     <= n_calc;
         if (sts.zero_probe) begin
            res_ff <= zero_res;
         end
      end
      if (cmd.walk_init) begin
         pos_ff <= (op_ff == OP_COMMIT) ? IW'(slot_rem) : IW'(rem);
         cnt_ff <= '0;
      end
      if (cmd.step) begin
         if (op_ff == OP_COMMIT) begin
            res_ff <= commit_res;
         end else begin
            cand_ff   <= cand_next;
            cguard_ff <= cguard_next;
            ctie_ff   <= ctie_next;
            if (walk_end) begin
               res_ff <= probe_res;
            end else begin
               pos_ff <= (CW'(pos_ff) == n_ff - CW'(1)) ? '0 : pos_ff + IW'(1);
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
      end
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   always_comb begin
      sts.clr_last   = (clr_ff == IW'(SLOTS - 1));
      sts.zero_probe = (req_tuser == OP_PROBE) && (n_calc == '0);
      sts.div_done   = div_done;
      sts.is_commit  = (op_ff == OP_COMMIT);
      sts.walk_end   = walk_end;
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {4'b0000, out_ff.observed, out_ff.ctie, out_ff.cguard,
                        out_ff.cidx, out_ff.tomb, out_ff.found};

endmodule

`default_nettype wire

>>> sv/ept_ctrl.sv
// ---------------------------------------------------------------------------
// ept_ctrl
// Sequencer for clearing, remainder, slot walk, commit and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module ept_ctrl import ept_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_DIV   = 6'b000100,
      S_RD    = 6'b001000,
      S_EV    = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (sts.zero_probe) begin
                  state_in = S_DONE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            // A commit's slot number is ready in the cycle after it is taken.
            if (sts.div_done || sts.is_commit) begin
               cmd.walk_init = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_EV;
         end
         S_EV: begin
            cmd.step = 1'b1;
            if (sts.is_commit || sts.walk_end) begin
               state_in = S_DONE;
            end else begin
               state_in = S_RD;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/epoch_guarded_linear_probe_table.sv
// ---------------------------------------------------------------------------
// epoch_guarded_linear_probe_table
// Linear-probe slot table with epoch guards, probe and commit operations.
// ---------------------------------------------------------------------------
//
//   Port group  Direction  Word contents (low bit first)
//   req_*       in         tuser: opcode; tdata: probe_hash, target_slot,
//                          guard_expect, new_visible_epoch, new_flags,
//                          new_tie_breaker, zero fill
//   rsp_*       out        tuser: status; tdata: found, tombstone,
//                          candidate_index, candidate_guard_epoch,
//                          candidate_tie_breaker, guard_seen, zero fill
//   csr_*       in         wr_data: slots_in_use
//
// A probe is accepted, then the one-bit-per-cycle remainder unit finds the home
// slot, then each visited slot (1 to the slot count) takes a memory read and an
// evaluate step, and a hand-off follows before req_tready returns. A probe with
// a slot count of zero goes straight from acceptance to the hand-off. A commit
// reduces its slot number by a reciprocal multiplication, then one read and one
// evaluate step do the read-modify-write, followed by the hand-off.
// After reset the table is swept to zero, one slot per cycle, with req_tready
// low. A result waiting on rsp_tready does not block accepting the next word;
// only the final hand-off waits for the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module epoch_guarded_linear_probe_table import ept_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tuser: opcode
   input  logic                  req_tuser,
   // tdata: probe_hash, target_slot, guard_expect, new_visible_epoch,
   // new_flags, new_tie_breaker
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tuser: status
   output logic [1:0]            rsp_tuser,
   // tdata: found, tombstone, candidate_index, candidate_guard_epoch,
   // candidate_tie_breaker, guard_seen
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_W-1:0]      csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   // The controller sequences the work; it sees only status from the datapath.
   ept_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the slot memory, the walk registers and the result.
   ept_datapath #(.SLOTS(SLOTS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // No word may be taken while the clearing sweep is still writing.
   `ASSERT_SAME(a_no_accept_in_clear, clock, reset, cmd.clr, !req_tready)
   // Only one word is in work at a time.
   `ASSERT_NEXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)
   // A result is never loaded over one that is still waiting.
   `ASSERT_SAME(a_out_load_free, clock, reset, cmd.out_load, sts.out_free)
   // Sweep, read, evaluate and hand-off never overlap.
   `ASSERT_SAME(a_phase_excl, clock, reset, 1'b1, $onehot0({cmd.clr, cmd.rd, cmd.step, cmd.out_load}))

endmodule

`default_nettype wire

>>> tb/probe_table_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// probe_table_checker
// Watches the request, response and register ports of the slot table. It
// keeps its own copy of every slot and the slot count, works out the
// expected response word for each accepted request word, and compares each
// accepted response word with the oldest expected one, field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module probe_table_checker import ept_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   input  wire                  req_tready,
   input  wire                  req_tuser,
   input  wire [REQ_DATA_W-1:0] req_tdata,
   input  wire                  rsp_tvalid,
   input  wire                  rsp_tready,
   input  wire [1:0]            rsp_tuser,
   input  wire [RSP_DATA_W-1:0] rsp_tdata,
   input  wire                  csr_wr_en,
   input  wire [CSR_W-1:0]      csr_wr_data,
   output int                   mismatches,
   output int                   pending,
   output int                   hits,
   output int                   fulls
);

   localparam int NSLOT = SLOTS_DEFAULT;

   logic [EPOCH_W-1:0] guard_mem [NSLOT];
   logic [EPOCH_W-1:0] vis_mem   [NSLOT];
   logic [EPOCH_W-1:0] key_mem   [NSLOT];
   logic [EPOCH_W-1:0] tie_mem   [NSLOT];
   logic [1:0]         flag_mem  [NSLOT];
   logic [CSR_W-1:0]   slot_count;
   result_type         answers_due [$];

   function automatic result_type lookup_key(logic [EPOCH_W-1:0] key);
      result_type r;
      int n;
      int home;
      int i;
      bit have;
      int cand;
      logic [1:0] f;
      r    = '0;
      have = 0;
      cand = 0;
      n    = (slot_count > NSLOT) ? NSLOT : int'(slot_count);
      if (n == 0) begin
         r.status = ST_NO_SLOTS;
         return r;
      end
      home = int'(key % 64'(n));
      for (int k = 0; k < n; k++) begin
         i = (home + k) % n;
         f = flag_mem[i];
         if (guard_mem[i] != vis_mem[i]) continue;
         if (f[FLAG_VALID] && key_mem[i] == key) begin
            r.status = ST_PROBE_OK;
            r.found  = 1'b1;
            r.tomb   = f[FLAG_TOMB];
            r.cidx   = i[CIDX_W-1:0];
            r.cguard = guard_mem[i];
            r.ctie   = tie_mem[i];
            return r;
         end
         if (f[FLAG_VALID] && f[FLAG_TOMB]) begin
            if (!have) begin
               have = 1;
               cand = i;
            end
            continue;
         end
         if (guard_mem[i] == '0 && vis_mem[i] == '0 && key_mem[i] == '0 && f == 2'b00) begin
            if (!have) begin
               have = 1;
               cand = i;
            end
            break;
         end
      end
      if (!have) begin
         r.status = ST_FULL;
         return r;
      end
      r.status = ST_PROBE_OK;
      r.cidx   = cand[CIDX_W-1:0];
      r.cguard = guard_mem[cand];
      r.ctie   = tie_mem[cand];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [EPOCH_W-1:0] got,
                                  logic [EPOCH_W-1:0] want);
      $display("mismatch in %s: got %h, expected %h", field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      result_type want;
      int idx;
      logic [EPOCH_W-1:0] cmp;
      logic [EPOCH_W-1:0] nvis;
      if (reset) begin
         for (int s = 0; s < NSLOT; s++) begin
            guard_mem[s] = '0;
            vis_mem[s]   = '0;
            key_mem[s]   = '0;
            tie_mem[s]   = '0;
            flag_mem[s]  = '0;
         end
         slot_count = CSR_RESET;
         answers_due.delete();
         mismatches = 0;
         hits       = 0;
         fulls      = 0;
      end else begin
         if (csr_wr_en) slot_count = csr_wr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_PROBE) begin
               want = lookup_key(req_tdata[63:0]);
               if (want.found) hits++;
               if (want.status == ST_FULL) fulls++;
            end else begin
               idx  = int'(req_tdata[73:64]);
               cmp  = req_tdata[137:74];
               nvis = req_tdata[201:138];
               vis_mem[idx]  = nvis;
               key_mem[idx]  = req_tdata[63:0];
               flag_mem[idx] = req_tdata[203:202];
               tie_mem[idx]  = req_tdata[267:204];
               want          = '0;
               want.status   = ST_COMMIT;
               want.observed = guard_mem[idx];
               if (guard_mem[idx] == cmp) guard_mem[idx] = nvis;
            end
            answers_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[63:0], '0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_tuser != want.status)
                  report_mismatch("status", EPOCH_W'(rsp_tuser), EPOCH_W'(want.status));
               if (rsp_tdata[0] != want.found)
                  report_mismatch("found", EPOCH_W'(rsp_tdata[0]), EPOCH_W'(want.found));
               if (rsp_tdata[1] != want.tomb)
                  report_mismatch("tombstone", EPOCH_W'(rsp_tdata[1]), EPOCH_W'(want.tomb));
               if (rsp_tdata[11:2] != want.cidx)
                  report_mismatch("candidate_index", EPOCH_W'(rsp_tdata[11:2]),
                                  EPOCH_W'(want.cidx));
               if (rsp_tdata[75:12] != want.cguard)
                  report_mismatch("candidate_guard_epoch", rsp_tdata[75:12], want.cguard);
               if (rsp_tdata[139:76] != want.ctie)
                  report_mismatch("candidate_tie_breaker", rsp_tdata[139:76], want.ctie);
               if (rsp_tdata[203:140] != want.observed)
                  report_mismatch("guard_seen", rsp_tdata[203:140], want.observed);
               if (rsp_tdata[207:204] != 4'd0)
                  report_mismatch("zero fill", EPOCH_W'(rsp_tdata[207:204]), '0);
            end
         end
      end
      pending = answers_due.size();
   end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the epoch-guarded linear-probe slot table.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top import ept_pkg::*; ();

   // The worst probe walks the whole table; this limit leaves a wide margin
   // over the slowest correct run including stalls.
   localparam int CYCLE_LIMIT = 8000000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // Fields from the lowest bit up: opcode.
   logic                  req_tuser   = OP_PROBE;
   // Fields from the lowest bit up: probe_hash, target_slot, guard_expect,
   // new_visible_epoch, new_flags, new_tie_breaker, zero fill.
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // Fields from the lowest bit up: status.
   logic [1:0]            rsp_tuser;
   // Fields from the lowest bit up: found, tombstone, candidate_index,
   // candidate_guard_epoch, candidate_tie_breaker, guard_seen, zero fill.
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_W-1:0]      csr_wr_data = '0;

   int mismatches;
   int pending;
   int hits;
   int fulls;

   // Effective slot count used for shaping the random words.
   int  live_slots = SLOTS_DEFAULT;
   bit  quiet      = 1'b0;
   int  probes_sent  = 0;
   int  commits_sent = 0;
   int  cycles       = 0;
   int  rsp_stall    = 0;
   logic [EPOCH_W-1:0] key_pool [8];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   epoch_guarded_linear_probe_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   probe_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatches (mismatches),
      .pending    (pending),
      .hits       (hits),
      .fulls      (fulls)
   );

   // The response side stalls in short random bursts unless the run is in
   // its quiet tail, where every response word is taken at once.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall  = rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: a hung block ends the run as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Presents one request word and holds it until the block takes it. The
   // valid line stays high afterwards so back-to-back words need no gap.
   task automatic send_word(logic op, logic [63:0] key, logic [9:0] idx,
                            logic [63:0] cmp, logic [63:0] nvis,
                            logic [1:0] flags, logic [63:0] tie);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, tie, flags, nvis, cmp, idx, key};
      if (op == OP_PROBE) probes_sent++;
      else commits_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drops the request line and waits for every response word to drain,
   // so the slot count can be changed on an idle block.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_slot_count(logic [CSR_W-1:0] count);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      live_slots = (count > SLOTS_DEFAULT) ? SLOTS_DEFAULT : int'(count);
   endtask

   function automatic logic [63:0] pick_key();
      if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
      return key_pool[$urandom_range(0, 7)];
   endfunction

   // Most epochs come from a tiny set so that guards and visible epochs
   // often agree and compare-and-swap succeeds often enough.
   function automatic logic [63:0] pick_epoch();
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      return 64'($urandom_range(0, 2));
   endfunction

   // One random word. Commits cluster around the home slots of the pooled
   // keys so that probes meet collisions, tombstones and stale slots.
   task automatic random_word;
      logic [63:0] key;
      logic [63:0] nvis;
      logic [1:0]  flags;
      logic [9:0]  idx;
      int          span;
      span = (live_slots == 0) ? SLOTS_DEFAULT : live_slots;
      key  = pick_key();
      if ($urandom_range(0, 99) < 55) begin
         send_word(OP_PROBE, key, 10'($urandom), {$urandom, $urandom},
                   {$urandom, $urandom}, 2'($urandom), {$urandom, $urandom});
      end else begin
         flags = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 9) < 7)
            idx = 10'((int'(key % 64'(span)) + $urandom_range(0, 3)) % span);
         else
            idx = 10'($urandom);
         nvis = pick_epoch();
         // Sometimes write a slot back to fully empty.
         if (flags == 2'b00 && $urandom_range(0, 1) == 0) begin
            key  = '0;
            nvis = '0;
         end
         send_word(OP_COMMIT, key, idx, pick_epoch(), nvis, flags,
                   {$urandom, $urandom});
      end
   endtask

   localparam int NPHASE = 11;
   logic [CSR_W-1:0] phase_count [NPHASE] = '{
      11'd0, 11'd1, 11'd4, 11'd2047, 11'd3, 11'd8, 11'd1024,
      11'd16, 11'd2, 11'd5, 11'd1024
   };

   initial begin
      for (int p = 0; p < 8; p++)
         key_pool[p] = (p < 4) ? 64'(p * 5 + 1) : {$urandom, $urandom};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // The block clears its table after reset with req_tready low.
      @(posedge clock);
      while (!req_tready) @(posedge clock);

      // Directed words at the reset slot count of 1024.
      send_word(OP_PROBE, 64'd0, 10'd0, '0, '0, 2'd0, '0);              // empty table
      send_word(OP_PROBE, '1, 10'd0, '0, '0, 2'd0, '0);                 // home at top slot
      send_word(OP_COMMIT, 64'd5, 10'd5, '0, '0, 2'd1, '1);
      send_word(OP_PROBE, 64'd5, 10'd0, '0, '0, 2'd0, '0);              // direct hit
      send_word(OP_COMMIT, 64'd1029, 10'd6, '0, '0, 2'd1, 64'd7);
      send_word(OP_PROBE, 64'd1029, 10'd0, '0, '0, 2'd0, '0);           // collision walk
      send_word(OP_COMMIT, 64'd5, 10'd5, '0, '0, 2'd3, 64'd9);          // tombstone
      send_word(OP_PROBE, 64'd5, 10'd0, '0, '0, 2'd0, '0);
      send_word(OP_PROBE, 64'd1029, 10'd0, '0, '0, 2'd0, '0);           // match beats tombstone
      send_word(OP_PROBE, 64'd2053, 10'd0, '0, '0, 2'd0, '0);           // tombstone candidate
      send_word(OP_COMMIT, 64'd0, 10'd7, 64'd9, 64'd9, 2'd0, '0);       // failed swap, stale slot
      send_word(OP_PROBE, 64'd2053, 10'd0, '0, '0, 2'd0, '0);           // skips stale slot
      send_word(OP_COMMIT, '1, 10'd1023, '0, '1, 2'd1, '1);
      send_word(OP_PROBE, '1, '1, '1, '1, 2'd3, '1);
      send_word(OP_COMMIT, '1, 10'd1023, '1, 64'd1, 2'd1, '0);          // observes all ones
      send_word(OP_COMMIT, 64'd0, 10'd2, '0, '0, 2'd2, '0);             // tombstone, not valid
      send_word(OP_PROBE, 64'd2, 10'd0, '0, '0, 2'd0, '0);              // passed-over slot
      send_word(OP_COMMIT, 64'd0, 10'd3, '0, '0, 2'd0, '1);             // rewritten empty
      send_word(OP_PROBE, 64'd3, 10'd0, '0, '0, 2'd0, '0);

      // Random phases, one per slot count; the last runs without idling.
      for (int ph = 0; ph < NPHASE; ph++) begin
         set_slot_count(phase_count[ph]);
         quiet = (ph == NPHASE - 1);
         repeat (100) random_word();
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d probes and %0d commits over %0d slot-count settings.",
               probes_sent, commits_sent, NPHASE + 1);
      $display("Probes with a key match: %0d, probes on a full walk: %0d.", hits, fulls);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
